// ===== sv/rdf_pkg.sv =====
// Package for the radix digit formatter: transaction structs, constants and
// the digit-to-ASCII glyph function. No dependencies.
package rdf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RADIX_MIN       = 2;
    localparam int RADIX_MAX       = 36;

    localparam logic [6:0] ASCII_ZERO   = 7'h30;
    // 'A' minus ten, so that digit ten maps onto 'A'.
    localparam logic [6:0] ASCII_LETTER = 7'h37;

    typedef struct packed {
        logic        [31:0] value;
        logic signed [7:0]  base;
    } t_fmt_in;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last_digit;
        logic       bad_base;
    } t_fmt_out;

    // Maps a remainder to its ASCII character; codes past the radix range give '0'.
    function automatic logic [6:0] digit_glyph(input logic [5:0] d);
        logic [6:0] g;
        if (d < 6'd10) begin
            g = ASCII_ZERO + {1'b0, d};
        end else if (d < 6'(RADIX_MAX)) begin
            g = ASCII_LETTER + {1'b0, d};
        end else begin
            g = ASCII_ZERO;
        end
        return g;
    endfunction

endpackage

// ===== sv/radix_digit_formatter.sv =====
// Radix digit formatter top level: a shared restoring divider, a digit memory
// and the sequencer that drives them. Depends on rdf_pkg.
// A bad base gives its single result in the cycle after start and never raises busy.
// A good base sends each digit through the divider steps and the store state, then reads the
// digits back through the load and emit states. Busy stays high until the last digit is emitted;
// its strobe comes as busy falls. Reset is synchronous, active low; results cannot be stalled.
module radix_digit_formatter
    import rdf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_fmt_in  i_item,
    output logic     o_strobe,
    output t_fmt_out o_result
);

    // Width of the step counter, the digit count and the memory address.
    localparam int SW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int IW = $clog2(VALUE_WIDTH);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_quo,   n_quo;
    logic [5:0]             r_rem,   n_rem;
    logic [5:0]             r_base,  n_base;
    logic [SW-1:0]          r_step,  n_step;
    logic [CW-1:0]          r_count, n_count;
    logic [IW-1:0]          r_ptr,   n_ptr;
    logic                   r_strobe, n_strobe;
    t_fmt_out               r_out,   n_out;

    // Digit memory: remainders in the order they come out of the divider,
    // least significant first. It is read back from the top down.
    logic [5:0] r_mem [VALUE_WIDTH];
    logic [5:0] r_rd_data;

    // One step of the shared restoring divider: bring down the next dividend bit
    // into the partial remainder and subtract the base when it fits.
    logic [6:0] w_trial;
    logic       w_fits;
    logic       w_base_ok;
    logic       w_accept;

    assign w_trial  = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign w_fits   = (w_trial >= {1'b0, r_base});
    assign w_accept = start && (r_state == ST_IDLE);

    // The base is taken as an 8-bit pattern; only 2 through 36 are legal.
    assign w_base_ok = !i_item.base[7]
                    && (i_item.base[6:0] >= 7'(RADIX_MIN))
                    && (i_item.base[6:0] <= 7'(RADIX_MAX));

    always_comb begin
        n_state  = r_state;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_base   = r_base;
        n_step   = r_step;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_strobe = 1'b0;
        n_out    = r_out;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_quo = VALUE_WIDTH'(i_item.value);
                    if (w_base_ok) begin
                        n_base  = i_item.base[5:0];
                        n_rem   = '0;
                        n_step  = '0;
                        n_count = '0;
                        n_state = ST_DIV;
                    end else begin
                        // A bad base answers at once with a single flagged result.
                        n_count  = '0;
                        n_strobe = 1'b1;
                        n_out    = '{digit_char: '0, last_digit: 1'b0, bad_base: 1'b1};
                    end
                end
            end
            ST_DIV: begin
                n_quo = {r_quo[VALUE_WIDTH-2:0], w_fits};
                n_rem = w_fits ? 6'(w_trial - {1'b0, r_base}) : w_trial[5:0];
                n_step = r_step + 1'b1;
                if (r_step == SW'(VALUE_WIDTH - 1)) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                // The remainder is written to memory this cycle. A zero value
                // still passes once through here and yields the digit zero.
                n_count = r_count + 1'b1;
                if (r_quo == '0) begin
                    n_ptr   = r_count[IW-1:0];
                    n_state = ST_LOAD;
                end else begin
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_LOAD: begin
                // The memory read at r_ptr is registered at this edge.
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                n_out    = '{digit_char: digit_glyph(r_rd_data),
                             last_digit: (r_ptr == '0),
                             bad_base:   1'b0};
                if (r_ptr == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_ptr   = r_ptr - 1'b1;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_count  <= '0;
            r_quo    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_count  <= n_count;
            r_quo    <= n_quo;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_base <= n_base;
        r_step <= n_step;
        r_ptr  <= n_ptr;
        r_out  <= n_out;
    end

    // Digit memory: one write port from the divider, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_STORE) begin
            r_mem[r_count[IW-1:0]] <= r_rem;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule
